FILE: design/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg
// Shared constants, request and outcome codes, and the control structs of the
// block read cache tag and policy unit.
// ----------------------------------------------------------------------------
`default_nettype none

package brc_pkg;

    localparam int BLK_BITS      = 64;
    localparam int LRU_SETS      = 32;
    localparam int SET_BITS      = $clog2(LRU_SETS);
    localparam int WINDOWS       = 4;
    localparam int SLOT_BITS     = $clog2(WINDOWS);
    localparam int COUNT_BITS    = $clog2(WINDOWS + 1);
    localparam int WINDOW_BLOCKS = 8;
    localparam int OFFS_BITS     = $clog2(WINDOW_BLOCKS);

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_FILL   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] OUT_LRU_HIT     = 3'd0;
    localparam logic [2:0] OUT_WINDOW_HIT  = 3'd1;
    localparam logic [2:0] OUT_READ_MISS   = 3'd2;
    localparam logic [2:0] OUT_WRITE_THRU  = 3'd3;
    localparam logic [2:0] OUT_FILLED      = 3'd4;
    localparam logic [2:0] OUT_FILL_FAILED = 3'd5;

    localparam int CFG_ADDR_BITS = 4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ADDR_OFFSET = 4'h0;

    typedef struct packed {
        logic hit;
        logic hit_way;
        logic fill_way;
    } way_look_t;

    typedef struct packed {
        logic touch_en;
        logic fill_en;
        logic way;
    } way_upd_t;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
        logic [OFFS_BITS-1:0] offset;
        logic [SLOT_BITS-1:0] append_slot;
    } win_look_t;

endpackage

`default_nettype wire

FILE: design/block_read_cache_tag_policy_unit.sv
// ----------------------------------------------------------------------------
// block_read_cache_tag_policy_unit
// Tag and policy engine of a block read cache: 32-set two-way LRU tag store
// and a FIFO of four readahead windows of eight blocks.
//
//   channel  dir  payload                                         ends on
//   s_       in   tuser req_type/fill_ok, tdata block_number      tvalid&tready
//   m_       out  tuser outcome, tdata set..device_block          tvalid&tready
//   apb      in   device_block_offset at byte address 0           psel&penable&pwrite
//
// one word per cycle sustained while m_tready holds; a word sits in the input register
// while the tag RAMs are read, then moves into the output register
// the output register stalls on m_tready, the input register only while the
// output holds an untaken result
// reset clears all valid and recency bits and the window count; no sweep
// req_type 3 is dropped without a result
// ----------------------------------------------------------------------------
`default_nettype none

module block_read_cache_tag_policy_unit import brc_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [63:0]              s_tdata,   // block_number
    input  wire logic [2:0]               s_tuser,   // req_type[1:0], fill_ok[2]
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [79:0]                   m_tdata,   // set_index[4:0], way_index[5],
                                                     // window_slot[7:6],
                                                     // window_offset[10:8],
                                                     // device_block[74:11], zero pad
    output logic [2:0]                    m_tuser,   // outcome
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [63:0]              pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);

    logic [BLK_BITS-1:0]  offset_reg;
    logic                 in_valid_reg;
    logic [1:0]           type_reg;
    logic [BLK_BITS-1:0]  blk_reg;
    logic                 ok_reg;
    logic                 m_valid_reg;
    logic [2:0]           outcome_reg;
    logic [SET_BITS-1:0]  set_reg;
    logic                 way_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [OFFS_BITS-1:0] offs_reg;
    logic [BLK_BITS-1:0]  dev_reg;
    logic [2:0]           outcome_next;
    logic                 way_next;
    logic [SLOT_BITS-1:0] slot_next;
    logic [OFFS_BITS-1:0] offs_next;
    logic [BLK_BITS-1:0]  dev_next;
    logic                 out_free;
    logic                 has_result;
    logic                 advance;
    logic                 accept;
    logic                 fill_go;
    logic [SET_BITS-1:0]  cur_set;
    logic [BLK_BITS-1:0]  dev_sum;
    way_look_t            way_look;
    way_upd_t             way_upd;
    win_look_t            win_look;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr == CFG_ADDR_OFFSET) ? offset_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr == CFG_ADDR_OFFSET) begin
            offset_reg <= pwdata;
        end
    end

    // handshake
    assign out_free   = !m_valid_reg || m_tready;
    assign has_result = (type_reg != REQ_UNUSED);
    assign advance    = in_valid_reg && (out_free || !has_result);
    assign s_tready   = !in_valid_reg || advance;
    assign accept     = s_tvalid && s_tready;
    assign cur_set    = blk_reg[SET_BITS-1:0];
    assign dev_sum    = blk_reg + offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            type_reg <= s_tuser[1:0];
            blk_reg  <= s_tdata;
            ok_reg   <= s_tuser[2];
        end
    end

    brc_lru_tags u_tags (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_set  (s_tdata[SET_BITS-1:0]),
        .cur_set (cur_set),
        .cur_blk (blk_reg),
        .upd     (way_upd),
        .look    (way_look)
    );

    brc_window_fifo u_windows (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cur_blk (blk_reg),
        .append  (fill_go),
        .look    (win_look)
    );

    assign fill_go = advance && (type_reg == REQ_FILL) && ok_reg;

    always_comb begin
        way_upd.fill_en  = fill_go;
        way_upd.touch_en = fill_go
                           || (advance && (type_reg == REQ_READ) && way_look.hit);
        way_upd.way      = (type_reg == REQ_FILL) ? way_look.fill_way : way_look.hit_way;
    end

    // result
    always_comb begin
        outcome_next = OUT_FILL_FAILED;
        way_next     = 1'b0;
        slot_next    = '0;
        offs_next    = '0;
        dev_next     = '0;
        case (type_reg)
            REQ_READ: begin
                if (way_look.hit) begin
                    outcome_next = OUT_LRU_HIT;
                    way_next     = way_look.hit_way;
                end else if (win_look.hit) begin
                    outcome_next = OUT_WINDOW_HIT;
                    slot_next    = win_look.slot;
                    offs_next    = win_look.offset;
                end else begin
                    outcome_next = OUT_READ_MISS;
                    dev_next     = dev_sum;
                end
            end
            REQ_WRITE: begin
                outcome_next = OUT_WRITE_THRU;
                dev_next     = dev_sum;
            end
            REQ_FILL: begin
                if (ok_reg) begin
                    outcome_next = OUT_FILLED;
                    way_next     = way_look.fill_way;
                    slot_next    = win_look.append_slot;
                end
            end
            default: begin
                outcome_next = OUT_FILL_FAILED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= advance && has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance) begin
            outcome_reg <= outcome_next;
            set_reg     <= cur_set;
            way_reg     <= way_next;
            slot_reg    <= slot_next;
            offs_reg    <= offs_next;
            dev_reg     <= dev_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = outcome_reg;
    assign m_tdata  = {5'd0, dev_reg, offs_reg, slot_reg, way_reg, set_reg};

endmodule

`default_nettype wire

FILE: design/brc_ram.sv
// ----------------------------------------------------------------------------
// brc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/brc_lru_tags.sv
// ----------------------------------------------------------------------------
// brc_lru_tags
// Two-way tag store with valid and recency bits, tag compare, victim choice
// and forwarding of a fill that lands in the cycle a new word reads its set.
// ----------------------------------------------------------------------------
`default_nettype none

module brc_lru_tags import brc_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                rd_en,
    input  wire logic [SET_BITS-1:0] rd_set,
    input  wire logic [SET_BITS-1:0] cur_set,
    input  wire logic [BLK_BITS-1:0] cur_blk,
    input  wire way_upd_t            upd,
    output way_look_t                look
);

    logic [BLK_BITS-1:0] rdata0;
    logic [BLK_BITS-1:0] rdata1;
    logic [BLK_BITS-1:0] tag0;
    logic [BLK_BITS-1:0] tag1;
    logic [LRU_SETS-1:0] valid0_reg;
    logic [LRU_SETS-1:0] valid1_reg;
    logic [LRU_SETS-1:0] recent_reg;
    logic                fwd_valid_reg;
    logic                fwd_way_reg;
    logic [BLK_BITS-1:0] fwd_tag_reg;
    logic                hit0;
    logic                hit1;
    logic                v0;
    logic                v1;

    brc_ram #(.WIDTH(BLK_BITS), .DEPTH(LRU_SETS)) u_way0 (
        .clk   (aclk),
        .we    (upd.fill_en && !upd.way),
        .waddr (cur_set),
        .wdata (cur_blk),
        .re    (rd_en),
        .raddr (rd_set),
        .rdata (rdata0)
    );

    brc_ram #(.WIDTH(BLK_BITS), .DEPTH(LRU_SETS)) u_way1 (
        .clk   (aclk),
        .we    (upd.fill_en && upd.way),
        .waddr (cur_set),
        .wdata (cur_blk),
        .re    (rd_en),
        .raddr (rd_set),
        .rdata (rdata1)
    );

    // fill of the same set retiring as the next word is read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_valid_reg <= upd.fill_en && (cur_set == rd_set);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_way_reg <= upd.way;
            fwd_tag_reg <= cur_blk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= '0;
            valid1_reg <= '0;
            recent_reg <= '0;
        end else begin
            if (upd.fill_en && !upd.way) begin
                valid0_reg[cur_set] <= 1'b1;
            end
            if (upd.fill_en && upd.way) begin
                valid1_reg[cur_set] <= 1'b1;
            end
            if (upd.touch_en) begin
                recent_reg[cur_set] <= upd.way;
            end
        end
    end

    always_comb begin
        tag0 = (fwd_valid_reg && !fwd_way_reg) ? fwd_tag_reg : rdata0;
        tag1 = (fwd_valid_reg && fwd_way_reg) ? fwd_tag_reg : rdata1;
        v0   = valid0_reg[cur_set];
        v1   = valid1_reg[cur_set];
        hit0 = v0 && (tag0 == cur_blk);
        hit1 = v1 && (tag1 == cur_blk);
        look.hit     = hit0 || hit1;
        look.hit_way = !hit0;
        if (hit0 || hit1) begin
            look.fill_way = !hit0;
        end else if (!v0) begin
            look.fill_way = 1'b0;
        end else if (!v1) begin
            look.fill_way = 1'b1;
        end else begin
            look.fill_way = !recent_reg[cur_set];
        end
    end

endmodule

`default_nettype wire

FILE: design/brc_window_fifo.sv
// ----------------------------------------------------------------------------
// brc_window_fifo
// Readahead window FIFO: base registers, oldest-first range lookup and
// append that overwrites the oldest window when full.
// ----------------------------------------------------------------------------
`default_nettype none

module brc_window_fifo import brc_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [BLK_BITS-1:0] cur_blk,
    input  wire logic                append,
    output win_look_t                look
);

    logic [BLK_BITS-1:0]   base_reg [WINDOWS];
    logic [COUNT_BITS-1:0] count_reg;
    logic [SLOT_BITS-1:0]  oldest_reg;
    logic                  full;
    logic [SLOT_BITS-1:0]  age_slot [WINDOWS];
    logic [BLK_BITS:0]     diff [WINDOWS];
    logic [WINDOWS-1:0]    match;

    assign full = (count_reg == COUNT_BITS'(WINDOWS));

    always_comb begin
        for (int i = 0; i < WINDOWS; i++) begin
            age_slot[i] = oldest_reg + SLOT_BITS'(i);
            diff[i]     = {1'b0, cur_blk} - {1'b0, base_reg[age_slot[i]]};
            match[i]    = (COUNT_BITS'(i) < count_reg) && !diff[i][BLK_BITS]
                          && (diff[i][BLK_BITS-1:OFFS_BITS] == '0);
        end
        look.hit    = 1'b0;
        look.slot   = '0;
        look.offset = '0;
        for (int i = WINDOWS - 1; i >= 0; i--) begin
            if (match[i]) begin
                look.hit    = 1'b1;
                look.slot   = age_slot[i];
                look.offset = diff[i][OFFS_BITS-1:0];
            end
        end
        look.append_slot = full ? oldest_reg : oldest_reg + count_reg[SLOT_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            oldest_reg <= '0;
        end else if (append) begin
            if (full) begin
                oldest_reg <= oldest_reg + SLOT_BITS'(1);
            end else begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (append) begin
            base_reg[look.append_slot] <= cur_blk;
        end
    end

endmodule

`default_nettype wire
